// ----- sv/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W        = 16;
  localparam int PROD_W        = 32;
  localparam int WIDE_W        = 33;
  // Quotient magnitude bits before saturation; a larger quotient is flagged.
  localparam int QBITS         = 17;
  // Holds a 33-bit magnitude shifted by up to 15 bits, and the divisor shifted by QBITS-1.
  localparam int NUM_W         = 48;
  localparam int DEN_W         = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic                      dz;
    logic signed [WIDE_W-1:0]  wide_r;
    logic signed [WIDE_W-1:0]  wide_i;
    logic                      neg_r;
    logic                      neg_i;
    logic                      ovf_r;
    logic                      ovf_i;
    logic [NUM_W-1:0]          rem_r;
    logic [NUM_W-1:0]          rem_i;
    logic [QBITS-1:0]          q_r;
    logic [QBITS-1:0]          q_i;
    logic [DEN_W-1:0]          den;
  } pipe_t;

  // Returns {saturated, value}.
  function automatic logic [DATA_W:0] sat16(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32767);
    lo = -WIDE_W'(32768);
    if (x > hi) begin
      return {1'b1, 16'h7fff};
    end else if (x < lo) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, x[DATA_W-1:0]};
  endfunction

endpackage

// ----- sv/cau_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_in_if / cau_out_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [15:0] a_real;
  logic signed [15:0] a_imag;
  logic signed [15:0] b_real;
  logic signed [15:0] b_imag;

  modport source (output valid, opcode, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, opcode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] res_real;
  logic signed [15:0] res_imag;
  logic [1:0]  status;

  modport source (output valid, res_real, res_imag, status, input ready);
  modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

// ----- sv/cau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Three stages: partial products, cross sums and divisor magnitude, then
// numerator magnitudes and the quotient overflow test.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_vld,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  output logic               vld,
  output pipe_t              pipe
);

  // Stage 1
  logic                      v1;
  op_t                       op1;
  logic signed [16:0]        as_r1, as_i1;
  logic signed [PROD_W-1:0]  p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;
  // Stage 2
  logic                      v2;
  op_t                       op2;
  logic signed [WIDE_W-1:0]  w_r2, w_i2, n_r2, n_i2;
  logic [DEN_W-1:0]          den2;
  // Stage 3 combinational
  logic [WIDE_W-1:0]         mag_r, mag_i;
  logic [NUM_W-1:0]          num_r, num_i;
  logic signed [WIDE_W-1:0]  mr_c, mi_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vld <= 1'b0;
    end else if (ce) begin
      v1 <= in_vld;
      v2 <= v1;
      vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      op1 <= op_t'(opcode);
      if (op_t'(opcode) == OP_SUB) begin
        as_r1 <= 17'(a_real) - 17'(b_real);
        as_i1 <= 17'(a_imag) - 17'(b_imag);
      end else begin
        as_r1 <= 17'(a_real) + 17'(b_real);
        as_i1 <= 17'(a_imag) + 17'(b_imag);
      end
      p_rr   <= a_real * b_real;
      p_ii   <= a_imag * b_imag;
      p_ri   <= a_real * b_imag;
      p_ir   <= a_imag * b_real;
      p_bb_r <= b_real * b_real;
      p_bb_i <= b_imag * b_imag;
    end
  end

  assign mr_c = WIDE_W'(p_rr) - WIDE_W'(p_ii);
  assign mi_c = WIDE_W'(p_ri) + WIDE_W'(p_ir);

  always_ff @(posedge clk) begin
    if (ce) begin
      op2  <= op1;
      if (op1 == OP_MUL) begin
        w_r2 <= mr_c >>> FRAC_BITS;
        w_i2 <= mi_c >>> FRAC_BITS;
      end else begin
        w_r2 <= WIDE_W'(as_r1);
        w_i2 <= WIDE_W'(as_i1);
      end
      n_r2 <= WIDE_W'(p_rr) + WIDE_W'(p_ii);
      n_i2 <= WIDE_W'(p_ir) - WIDE_W'(p_ri);
      den2 <= DEN_W'(p_bb_r) + DEN_W'(p_bb_i);
    end
  end

  assign mag_r = n_r2[WIDE_W-1] ? WIDE_W'(-n_r2) : WIDE_W'(n_r2);
  assign mag_i = n_i2[WIDE_W-1] ? WIDE_W'(-n_i2) : WIDE_W'(n_i2);
  assign num_r = NUM_W'(mag_r) << FRAC_BITS;
  assign num_i = NUM_W'(mag_i) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ce) begin
      pipe.op     <= op2;
      pipe.dz     <= (den2 == '0);
      pipe.wide_r <= w_r2;
      pipe.wide_i <= w_i2;
      pipe.neg_r  <= n_r2[WIDE_W-1];
      pipe.neg_i  <= n_i2[WIDE_W-1];
      // A quotient magnitude of 2^QBITS or more always saturates.
      pipe.ovf_r  <= ((num_r >> QBITS) >= NUM_W'(den2));
      pipe.ovf_i  <= ((num_i >> QBITS) >= NUM_W'(den2));
      pipe.rem_r  <= num_r;
      pipe.rem_i  <= num_i;
      pipe.q_r    <= '0;
      pipe.q_i    <= '0;
      pipe.den    <= den2;
    end
  end

endmodule

// ----- sv/cau_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div
// Restoring divider unrolled into one stage per quotient bit, MSB first.
// ----------------------------------------------------------------------------
module cau_div
  import cau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  ce,
  input  logic  in_vld,
  input  pipe_t in_pipe,
  output logic  vld,
  output pipe_t pipe
);

  logic  v   [QBITS+1];
  pipe_t stg [QBITS+1];

  assign v[0]   = in_vld;
  assign stg[0] = in_pipe;

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    localparam int K = QBITS - 1 - s;
    logic [NUM_W-1:0] dsh;
    logic             ge_r, ge_i;
    pipe_t            nxt;

    assign dsh  = NUM_W'(stg[s].den) << K;
    assign ge_r = stg[s].rem_r >= dsh;
    assign ge_i = stg[s].rem_i >= dsh;

    always_comb begin
      nxt = stg[s];
      if (ge_r) begin
        nxt.rem_r  = stg[s].rem_r - dsh;
        nxt.q_r[K] = 1'b1;
      end
      if (ge_i) begin
        nxt.rem_i  = stg[s].rem_i - dsh;
        nxt.q_i[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (ce) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        stg[s+1] <= nxt;
      end
    end
  end

  assign vld  = v[QBITS];
  assign pipe = stg[QBITS];

endmodule

// ----- sv/cau_sat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_sat
// Final stage: picks the result per opcode, saturates and sets the status.
// ----------------------------------------------------------------------------
module cau_sat
  import cau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_vld,
  input  pipe_t              pipe,
  output logic               vld,
  output logic signed [15:0] res_real,
  output logic signed [15:0] res_imag,
  output logic [1:0]         status
);

  logic signed [QBITS:0]    qs_r, qs_i;
  logic signed [WIDE_W-1:0] val_r, val_i;
  logic [DATA_W:0]          sr, si;
  logic [DATA_W-1:0]        r_nxt, i_nxt;
  status_t                  st_nxt;

  always_comb begin
    qs_r = {1'b0, pipe.q_r};
    qs_i = {1'b0, pipe.q_i};
    if (pipe.neg_r) begin
      qs_r = -qs_r;
    end
    if (pipe.neg_i) begin
      qs_i = -qs_i;
    end
    if (pipe.op == OP_DIV) begin
      val_r = WIDE_W'(qs_r);
      val_i = WIDE_W'(qs_i);
    end else begin
      val_r = pipe.wide_r;
      val_i = pipe.wide_i;
    end
    sr = sat16(val_r);
    si = sat16(val_i);
    if (pipe.op == OP_DIV && pipe.ovf_r) begin
      sr = pipe.neg_r ? {1'b1, 16'h8000} : {1'b1, 16'h7fff};
    end
    if (pipe.op == OP_DIV && pipe.ovf_i) begin
      si = pipe.neg_i ? {1'b1, 16'h8000} : {1'b1, 16'h7fff};
    end
    r_nxt  = sr[DATA_W-1:0];
    i_nxt  = si[DATA_W-1:0];
    st_nxt = (sr[DATA_W] || si[DATA_W]) ? ST_SAT : ST_OK;
    if (pipe.op == OP_DIV && pipe.dz) begin
      r_nxt  = '0;
      i_nxt  = '0;
      st_nxt = ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ce) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_real <= r_nxt;
      res_imag <= i_nxt;
      status   <= st_nxt;
    end
  end

endmodule

// ----- sv/complex_arithmetic_unit_core.sv -----
`timescale 1ns / 1ps
// Stages: 3 front, 17 divider and 1 output stage, the same path for every opcode.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output, so no item is taken then and bubbles stay in place.
// Reset: synchronous, clears all stage valid bits; no result is pending after it.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, subtract, multiply and divide on signed Q8.8 operands.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cau_in_if.sink     req,
  cau_out_if.source  rsp
);

  logic  ce;
  logic  f_vld, d_vld;
  pipe_t f_pipe, d_pipe;

  // A stage moves on unless the output holds an item that is not taken.
  assign ce        = !rsp.valid || rsp.ready;
  assign req.ready = ce;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .ce     (ce),
    .in_vld (req.valid),
    .opcode (req.opcode),
    .a_real (req.a_real),
    .a_imag (req.a_imag),
    .b_real (req.b_real),
    .b_imag (req.b_imag),
    .vld    (f_vld),
    .pipe   (f_pipe)
  );

  cau_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_vld  (f_vld),
    .in_pipe (f_pipe),
    .vld     (d_vld),
    .pipe    (d_pipe)
  );

  cau_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (d_vld),
    .pipe     (d_pipe),
    .vld      (rsp.valid),
    .res_real (rsp.res_real),
    .res_imag (rsp.res_imag),
    .status   (rsp.status)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_DZ |-> rsp.res_real == 16'sd0 && rsp.res_imag == 16'sd0)
    else $error("divide-by-zero result is not zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status == ST_OK || rsp.status == ST_SAT || rsp.status == ST_DZ)
    else $error("undefined status code");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_SAT |->
      rsp.res_real == 16'sh7fff || rsp.res_real == 16'sh8000 ||
      rsp.res_imag == 16'sh7fff || rsp.res_imag == 16'sh8000)
    else $error("saturated result has no part at a limit");

endmodule
